FILE: design/omc_pkg.sv
`default_nettype none
package omc_pkg;

  localparam int HIDDEN_COUNT    = 3;
  localparam int GROUP_ONE_MODES = 7;
  localparam int GROUP_TWO_MODES = 4;
  localparam int TABLE_SIZE      = 12;

  localparam logic [7:0] PWM_FAST    = 8'hA3;
  localparam logic [7:0] PWM_PHASE   = 8'hA1;
  localparam logic [7:0] CODE_BATT   = 8'd253;
  localparam logic [7:0] CODE_STROBE = 8'd254;
  localparam logic [7:0] CODE_TURBO  = 8'd255;
  localparam logic [3:0] PRESS_LIMIT = 4'h0f;

  localparam logic [7:0] MAIN_ONE [TABLE_SIZE] =
    '{8'd0, 8'd0, 8'd0, 8'd6, 8'd56, 8'd135, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam logic [7:0] AUX_ONE [TABLE_SIZE] =
    '{8'd3, 8'd20, 8'd100, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam logic [7:0] PWM_ONE [TABLE_SIZE] =
    '{PWM_PHASE, PWM_FAST, PWM_FAST, PWM_FAST, PWM_FAST, PWM_FAST,
      PWM_PHASE, PWM_PHASE, PWM_PHASE, PWM_PHASE, PWM_PHASE, PWM_PHASE};
  localparam logic [7:0] MAIN_TWO [TABLE_SIZE] =
    '{8'd0, 8'd0, 8'd79, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam logic [7:0] AUX_TWO [TABLE_SIZE] =
    '{8'd20, 8'd200, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam logic [7:0] PWM_TWO [TABLE_SIZE] =
    '{PWM_FAST, PWM_FAST, PWM_FAST, PWM_PHASE, PWM_PHASE, PWM_PHASE,
      PWM_PHASE, PWM_PHASE, PWM_PHASE, PWM_PHASE, PWM_PHASE, PWM_PHASE};
  localparam logic [7:0] HIDDEN_CODES [3] = '{CODE_BATT, CODE_STROBE, CODE_TURBO};
  localparam logic [7:0] BATT_LEVELS [5] = '{8'd118, 8'd141, 8'd155, 8'd165, 8'd174};

  typedef enum logic [1:0] {
    OP_POWER_UP = 2'd0,
    OP_TICK     = 2'd1,
    OP_SAMPLE   = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_STEADY = 2'd0,
    KIND_STROBE = 2'd1,
    KIND_BATT   = 2'd2
  } mode_kind_t;

  typedef enum logic [2:0] {
    REG_SHORT_LEVEL  = 3'd0,
    REG_MEDIUM_LEVEL = 3'd1,
    REG_LOW_LEVEL    = 3'd2,
    REG_TURBO_TICKS  = 3'd3,
    REG_MEMORY       = 3'd4,
    REG_LOW_REPEAT   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] cap_reading;
    logic [7:0] battery_sample;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  mode_index;
    logic [7:0]  main_level;
    logic [7:0]  aux_level;
    logic        fast_pwm;
    mode_kind_t  mode_kind;
    logic        config_toggled;
    logic        shutdown;
    logic [2:0]  battery_blinks;
    logic [1:0]  store_write;
    logic [15:0] store_word;
    logic [4:0]  store_slot;
  } out_item_t;

  typedef struct packed {
    logic [7:0] main;
    logic [7:0] aux;
    logic [7:0] pwm;
  } mode_entry_t;

  function automatic logic [3:0] solid_of(input logic gs);
    return gs ? 4'(GROUP_TWO_MODES) : 4'(GROUP_ONE_MODES);
  endfunction

  function automatic mode_entry_t read_mode(input logic gs, input logic [3:0] idx);
    logic [3:0]  solid;
    logic [3:0]  h;
    mode_entry_t e;
    solid = solid_of(gs);
    h = idx - solid;
    e.main = 8'd0;
    e.aux  = 8'd0;
    e.pwm  = PWM_PHASE;
    if (idx < solid) begin
      e.main = gs ? MAIN_TWO[idx] : MAIN_ONE[idx];
      e.aux  = gs ? AUX_TWO[idx] : AUX_ONE[idx];
      e.pwm  = gs ? PWM_TWO[idx] : PWM_ONE[idx];
    end else if (h < 4'(HIDDEN_COUNT)) begin
      e.main = HIDDEN_CODES[h[1:0]];
      e.aux  = e.main;
    end
    return e;
  endfunction

  function automatic mode_kind_t kind_of(input logic [7:0] m);
    if (m == CODE_BATT) return KIND_BATT;
    if (m == CODE_STROBE) return KIND_STROBE;
    return KIND_STEADY;
  endfunction

  function automatic logic [15:0] make_word(input logic [3:0] cm, input logic gs,
                                            input logic [3:0] pc);
    return {pc, 3'b000, gs, 4'b0000, cm};
  endfunction

endpackage
`default_nettype wire

FILE: design/offtime_mode_controller_core.sv
`default_nettype none
// Off-time mode controller for a two-channel light driver. Each input beat is
// one event: a power-up with the off-time capacitor reading, a half-second
// tick, or a battery voltage sample. Every event returns exactly one result
// beat with the mode index, PWM levels, mode kind, battery blinks and any state
// saves. An event enters the input register; the mode state and the result are
// computed from it and land in the output register, so one event per
// cycle flows through; the only limit is the output register, which holds
// while out_stall is high.
// Configuration writes are taken at any time on the cfg_ port (cfg_ready is
// always high) and must be issued only while no event is in flight.
module offtime_mode_controller_core
  import omc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  // configuration registers
  logic [7:0] short_level_r, medium_level_r, low_level_r, turbo_ticks_r;
  logic       memory_en_r;
  logic [3:0] low_repeat_r;

  // mode state
  logic [3:0] cur_mode_r, cur_mode_nxt;
  logic       group_r, group_nxt;
  logic [3:0] press_r, press_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [3:0] low_r, low_nxt;
  logic [4:0] slot_r, slot_nxt;
  logic       halted_r, halted_nxt;

  // input and output registers
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  logic out_take, s1_fire;

  assign out_take  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_take;
  assign in_stall  = s1_valid_r && !out_take;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  // Configuration writes; codes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_level_r  <= 8'd250;
      medium_level_r <= 8'd190;
      low_level_r    <= 8'd109;
      turbo_ticks_r  <= 8'd60;
      memory_en_r    <= 1'b0;
      low_repeat_r   <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHORT_LEVEL:  short_level_r  <= cfg_data;
        REG_MEDIUM_LEVEL: medium_level_r <= cfg_data;
        REG_LOW_LEVEL:    low_level_r    <= cfg_data;
        REG_TURBO_TICKS:  turbo_ticks_r  <= cfg_data;
        REG_MEMORY:       memory_en_r    <= cfg_data[0];
        REG_LOW_REPEAT:   low_repeat_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Event logic: one pass over the registered event and the current state.
  always_comb begin
    logic [3:0]  solid;
    logic [4:0]  step_mode;
    logic [1:0]  saves;
    logic [15:0] word;
    logic        toggled, shut;
    logic [2:0]  blinks;
    mode_entry_t e;
    mode_kind_t  kind;

    cur_mode_nxt = cur_mode_r;
    group_nxt    = group_r;
    press_nxt    = press_r;
    tick_nxt     = tick_r;
    low_nxt      = low_r;
    slot_nxt     = slot_r;
    halted_nxt   = halted_r;
    saves        = 2'd0;
    word         = 16'd0;
    toggled      = 1'b0;
    shut         = 1'b0;
    blinks       = 3'd0;
    solid        = solid_of(group_r);
    step_mode    = {1'b0, cur_mode_r} + 5'd1;
    e            = read_mode(group_r, cur_mode_r);
    kind         = kind_of(e.main);

    unique case (s1_item_r.opcode)
      OP_POWER_UP: begin
        halted_nxt = 1'b0;
        tick_nxt   = 8'd0;
        low_nxt    = 4'd0;
        if (s1_item_r.cap_reading > short_level_r) begin
          cur_mode_nxt = (step_mode >= {1'b0, solid}) ? 4'd0 : step_mode[3:0];
          if (press_r < PRESS_LIMIT) press_nxt = press_r + 4'd1;
        end else if (s1_item_r.cap_reading > medium_level_r) begin
          if (cur_mode_r == solid) cur_mode_nxt = 4'd0;
          else if (cur_mode_r != 4'd0) cur_mode_nxt = cur_mode_r - 4'd1;
          else cur_mode_nxt = solid + 4'(HIDDEN_COUNT) - 4'd1;
          press_nxt = 4'd0;
        end else begin
          press_nxt = 4'd0;
          if (!memory_en_r) cur_mode_nxt = 4'd0;
        end
        slot_nxt = slot_nxt + 5'd2;
        word     = make_word(cur_mode_nxt, group_nxt, press_nxt);
        saves    = 2'd1;
        // fifteen short presses flip the group and save again
        if (press_nxt == PRESS_LIMIT) begin
          press_nxt    = 4'd0;
          cur_mode_nxt = 4'd0;
          group_nxt    = !group_r;
          slot_nxt     = slot_nxt + 5'd2;
          word         = make_word(cur_mode_nxt, group_nxt, press_nxt);
          saves        = 2'd2;
          toggled      = 1'b1;
        end
      end
      OP_TICK: begin
        if (!halted_r && kind == KIND_STEADY) begin
          if (tick_r != 8'd255) tick_nxt = tick_r + 8'd1;
          // turbo timeout: drop to the second-highest solid mode
          if (tick_nxt > turbo_ticks_r && e.main == CODE_TURBO) begin
            cur_mode_nxt = (solid >= 4'd2) ? solid - 4'd2 : 4'd0;
            slot_nxt     = slot_nxt + 5'd2;
            word         = make_word(cur_mode_nxt, group_r, press_r);
            saves        = saves + 2'd1;
          end
          if (press_r != 4'd0) begin
            press_nxt = 4'd0;
            slot_nxt  = slot_nxt + 5'd2;
            word      = make_word(cur_mode_nxt, group_r, 4'd0);
            saves     = saves + 2'd1;
          end
        end
      end
      OP_SAMPLE: begin
        if (!halted_r) begin
          if (kind == KIND_BATT) begin
            for (int i = 0; i < 5; i++) begin
              blinks = blinks + 3'(s1_item_r.battery_sample > BATT_LEVELS[i]);
            end
          end
          if (s1_item_r.battery_sample < low_level_r) begin
            if (low_r != 4'd15) low_nxt = low_r + 4'd1;
          end else begin
            low_nxt = 4'd0;
          end
          if (low_nxt >= low_repeat_r) begin
            low_nxt = 4'd0;
            if (cur_mode_r >= solid) begin
              cur_mode_nxt = 4'd2;
              slot_nxt     = slot_r + 5'd2;
              word         = make_word(cur_mode_nxt, group_r, press_r);
              saves        = 2'd1;
            end else if (cur_mode_r != 4'd0) begin
              cur_mode_nxt = cur_mode_r - 4'd1;
              slot_nxt     = slot_r + 5'd2;
              word         = make_word(cur_mode_nxt, group_r, press_r);
              saves        = 2'd1;
            end else begin
              halted_nxt = 1'b1;
            end
          end
        end
      end
      OP_NONE: ;
      default: ;
    endcase

    // result from the state this event leaves behind
    e    = read_mode(group_nxt, cur_mode_nxt);
    kind = kind_of(e.main);
    if (halted_nxt) begin
      shut = 1'b1;
      kind = KIND_STEADY;
    end

    out_item_nxt.mode_index     = cur_mode_nxt;
    out_item_nxt.main_level     = 8'd0;
    out_item_nxt.aux_level      = 8'd0;
    out_item_nxt.fast_pwm       = 1'b0;
    out_item_nxt.mode_kind      = kind;
    out_item_nxt.config_toggled = toggled;
    out_item_nxt.shutdown       = shut;
    out_item_nxt.battery_blinks = blinks;
    out_item_nxt.store_write    = saves;
    out_item_nxt.store_word     = word;
    out_item_nxt.store_slot     = slot_nxt;
    if (!halted_nxt && kind == KIND_STEADY) begin
      out_item_nxt.main_level = e.main;
      out_item_nxt.aux_level  = e.aux;
      out_item_nxt.fast_pwm   = (e.pwm == PWM_FAST) && ((e.main | e.aux) != 8'd0);
    end
  end

  // Input register: load a beat whenever the slot is free or moving on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  // Advance state only when the event moves into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mode_r <= 4'd0;
      group_r    <= 1'b0;
      press_r    <= 4'd0;
      tick_r     <= 8'd0;
      low_r      <= 4'd0;
      slot_r     <= 5'd0;
      halted_r   <= 1'b0;
    end else if (s1_fire) begin
      cur_mode_r <= cur_mode_nxt;
      group_r    <= group_nxt;
      press_r    <= press_nxt;
      tick_r     <= tick_nxt;
      low_r      <= low_nxt;
      slot_r     <= slot_nxt;
      halted_r   <= halted_nxt;
    end
  end

  // Output register: hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  // A beat with no saves reports a zero store word.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.store_write == 2'd0 |-> out_item.store_word == 16'd0)
    else $error("store word set without a save");

  // Shutdown shows a dark, steady result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.shutdown |->
      out_item.main_level == 8'd0 && out_item.aux_level == 8'd0 && !out_item.fast_pwm)
    else $error("light level during shutdown");

  // Save slot stays even and matches the state register once delivered.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_item.store_slot == slot_r && !out_item.store_slot[0])
    else $error("save slot out of step");

  // Group toggle always reports two saves and mode zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.config_toggled |->
      out_item.store_write == 2'd2 && out_item.mode_index == 4'd0)
    else $error("group toggle without double save");

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import omc_pkg::*;

  // Mode tables of both groups, kept separate from the design's package copy.
  localparam int N_ONE    = 7;
  localparam int N_TWO    = 4;
  localparam int N_HIDDEN = 3;

  localparam logic [7:0] LVL_BATT_CHECK = 8'd253;
  localparam logic [7:0] LVL_STROBE     = 8'd254;
  localparam logic [7:0] LVL_TURBO      = 8'd255;
  localparam logic [3:0] PRESS_MAX      = 4'hf;

  localparam logic [7:0] ONE_MAIN [N_ONE] = '{8'd0, 8'd0, 8'd0, 8'd6, 8'd56, 8'd135, 8'd255};
  localparam logic [7:0] ONE_AUX  [N_ONE] =
    '{8'd3, 8'd20, 8'd100, 8'd255, 8'd255, 8'd255, 8'd0};
  localparam bit         ONE_FAST [N_ONE] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam logic [7:0] TWO_MAIN [N_TWO] = '{8'd0, 8'd0, 8'd79, 8'd255};
  localparam logic [7:0] TWO_AUX  [N_TWO] = '{8'd20, 8'd200, 8'd255, 8'd0};
  localparam bit         TWO_FAST [N_TWO] = '{1'b1, 1'b1, 1'b1, 1'b0};
  localparam logic [7:0] HIDDEN_LEVEL [N_HIDDEN] = '{LVL_BATT_CHECK, LVL_STROBE, LVL_TURBO};
  localparam logic [7:0] BLINK_STEPS [5] = '{8'd118, 8'd141, 8'd155, 8'd165, 8'd174};

  localparam int HALT_ROW        = 16;   // first directed row run with repeat zero
  localparam int N_PHASES        = 7;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int WATCHDOG_LIMIT  = 1500;

  typedef enum {PRESS_SHORT, PRESS_MEDIUM, PRESS_LONG} press_t;

  typedef struct {
    in_item_t  ev;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  // Controller state as the bench tracks it.
  logic [3:0] mode_q    = 4'd0;
  logic       group_q   = 1'b0;
  logic [3:0] presses   = 4'd0;
  logic [7:0] ticks     = 8'd0;
  logic [3:0] lows      = 4'd0;
  logic [4:0] slot      = 5'd0;
  logic       halted_q  = 1'b0;

  // Register copies, at their power-on values.
  logic [7:0] short_lvl = 8'd250;
  logic [7:0] med_lvl   = 8'd190;
  logic [7:0] lowv_lvl  = 8'd109;
  logic [7:0] turbo_lim = 8'd60;
  logic       mem_en    = 1'b0;
  logic [3:0] low_rep   = 4'd8;

  out_item_t responses_due [$];
  stim_row_t stim_table [$];
  int        errors      = 0;
  int        calm_items  = 0;
  int        idle_cycles = 0;

  offtime_mode_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Look up the levels of a mode in the current group. Hidden modes follow the
  // solid ones; anything past them reads dark and phase-correct.
  function automatic void lookup_mode(input logic [3:0] idx, output logic [7:0] m,
                                      output logic [7:0] a, output logic fast_tab);
    int solid;
    int h;
    solid = group_q ? N_TWO : N_ONE;
    h = int'(idx) - solid;
    m = 8'd0;
    a = 8'd0;
    fast_tab = 1'b0;
    if (h < 0) begin
      if (group_q) begin
        m = TWO_MAIN[idx];
        a = TWO_AUX[idx];
        fast_tab = TWO_FAST[idx];
      end else begin
        m = ONE_MAIN[idx];
        a = ONE_AUX[idx];
        fast_tab = ONE_FAST[idx];
      end
    end else if (h < N_HIDDEN) begin
      m = HIDDEN_LEVEL[h];
      a = m;
    end
  endfunction

  function automatic mode_kind_t kind_for(input logic [7:0] m);
    if (m == LVL_BATT_CHECK) return KIND_BATT;
    if (m == LVL_STROBE) return KIND_STROBE;
    return KIND_STEADY;
  endfunction

  // Advance the wear-levelling slot and capture the saved word.
  function automatic void record_save(inout out_item_t r);
    slot = slot + 5'd2;
    r.store_write = r.store_write + 2'd1;
    r.store_word = {presses, 3'b000, group_q, 4'b0000, mode_q};
  endfunction

  // Apply one event to the tracked state and return the result beat it causes.
  function automatic out_item_t controller_response(input in_item_t ev);
    out_item_t  r;
    logic [7:0] m;
    logic [7:0] a;
    logic       f;
    int         solid;
    int         nxt;
    r = '0;
    solid = group_q ? N_TWO : N_ONE;
    case (ev.opcode)
      OP_POWER_UP: begin
        halted_q = 1'b0;
        ticks = 8'd0;
        lows = 4'd0;
        if (ev.cap_reading > short_lvl) begin
          // Step forward; wrapping to the first mode skips the hidden ones.
          nxt = int'(mode_q) + 1;
          mode_q = (nxt >= solid) ? 4'd0 : 4'(nxt);
          if (presses < PRESS_MAX) presses = presses + 4'd1;
        end else if (ev.cap_reading > med_lvl) begin
          // Step back; below the first mode lands on the last hidden one.
          if (int'(mode_q) == solid) mode_q = 4'd0;
          else if (mode_q != 4'd0) mode_q = mode_q - 4'd1;
          else mode_q = 4'(solid + N_HIDDEN - 1);
          presses = 4'd0;
        end else begin
          presses = 4'd0;
          if (!mem_en) mode_q = 4'd0;
        end
        record_save(r);
        if (presses == PRESS_MAX) begin
          // Enough fast presses: flip the group and restart at its first mode.
          presses = 4'd0;
          mode_q = 4'd0;
          group_q = ~group_q;
          record_save(r);
          r.config_toggled = 1'b1;
        end
      end
      OP_TICK: begin
        if (!halted_q) begin
          lookup_mode(mode_q, m, a, f);
          if (kind_for(m) == KIND_STEADY) begin
            if (ticks != 8'hff) ticks = ticks + 8'd1;
            if (ticks > turbo_lim && m == LVL_TURBO) begin
              mode_q = 4'(solid - 2);
              record_save(r);
            end
            if (presses != 4'd0) begin
              presses = 4'd0;
              record_save(r);
            end
          end
        end
      end
      OP_SAMPLE: begin
        if (!halted_q) begin
          lookup_mode(mode_q, m, a, f);
          if (kind_for(m) == KIND_BATT) begin
            for (int i = 0; i < 5; i++)
              if (ev.battery_sample > BLINK_STEPS[i]) r.battery_blinks = r.battery_blinks + 3'd1;
          end
          if (ev.battery_sample < lowv_lvl) begin
            if (lows != 4'hf) lows = lows + 4'd1;
          end else begin
            lows = 4'd0;
          end
          if (lows >= low_rep) begin
            // Step down; hidden modes drop to mode 2, mode 0 shuts the light off.
            lows = 4'd0;
            if (int'(mode_q) >= solid) begin
              mode_q = 4'd2;
              record_save(r);
            end else if (mode_q != 4'd0) begin
              mode_q = mode_q - 4'd1;
              record_save(r);
            end else begin
              halted_q = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    r.mode_index = mode_q;
    r.store_slot = slot;
    if (halted_q) begin
      r.shutdown = 1'b1;
    end else begin
      lookup_mode(mode_q, m, a, f);
      r.mode_kind = kind_for(m);
      if (r.mode_kind == KIND_STEADY) begin
        r.main_level = m;
        r.aux_level = a;
        r.fast_pwm = f && ((m | a) != 8'd0);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_event(input opcode_t op, input logic [7:0] cap,
                                          input logic [7:0] bat);
    in_item_t ev;
    ev.opcode = op;
    ev.cap_reading = cap;
    ev.battery_sample = bat;
    return ev;
  endfunction

  function automatic out_item_t result_of(input logic [3:0] mode, input logic [7:0] main_l,
                                          input logic [7:0] aux_l, input logic fast,
                                          input mode_kind_t kind, input logic [2:0] blinks,
                                          input logic shut, input logic [1:0] saves,
                                          input logic [15:0] word, input logic [4:0] pos);
    out_item_t r;
    r = '0;
    r.mode_index = mode;
    r.main_level = main_l;
    r.aux_level = aux_l;
    r.fast_pwm = fast;
    r.mode_kind = kind;
    r.shutdown = shut;
    r.battery_blinks = blinks;
    r.store_write = saves;
    r.store_word = word;
    r.store_slot = pos;
    return r;
  endfunction

  function automatic void add_row(input in_item_t ev, input bit typed, input out_item_t want);
    stim_row_t row;
    row.ev = ev;
    row.typed = typed;
    row.want = want;
    stim_table.push_back(row);
  endfunction

  // Pick a capacitor reading that lands in the requested press class under the
  // current thresholds; fall back to any reading when the class is empty.
  function automatic logic [7:0] pick_cap(input press_t p);
    int lim;
    case (p)
      PRESS_SHORT: begin
        if (short_lvl != 8'hff) return 8'($urandom_range(255, int'(short_lvl) + 1));
      end
      PRESS_MEDIUM: begin
        if (med_lvl < short_lvl)
          return 8'($urandom_range(int'(short_lvl), int'(med_lvl) + 1));
      end
      default: begin
        lim = (med_lvl < short_lvl) ? int'(med_lvl) : int'(short_lvl);
        return 8'($urandom_range(lim, 0));
      end
    endcase
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_battery(input bit low);
    if (low && lowv_lvl != 8'd0) return 8'($urandom_range(int'(lowv_lvl) - 1, 0));
    if (!low) return 8'($urandom_range(255, int'(lowv_lvl)));
    return 8'($urandom);
  endfunction

  // Present one event beat after a random gap and hold it until accepted.
  // Starts and ends on a falling edge; valid stays high for a back-to-back beat.
  task automatic drive_event(input in_item_t ev, input bit typed, input out_item_t want);
    int        gap;
    int        r;
    out_item_t predicted;
    r = $urandom_range(99);
    if (calm_items > 0) begin
      calm_items--;
      gap = 0;
    end else if (r < 3) begin
      calm_items = $urandom_range(100, 30);
      gap = 0;
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 88) begin
      gap = $urandom_range(3, 1);
    end else if (r < 97) begin
      gap = $urandom_range(12, 4);
    end else begin
      gap = $urandom_range(40, 15);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = ev;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    // Track state on every accepted beat; queue the typed value where given.
    predicted = controller_response(ev);
    responses_due.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Drop valid and wait for the pipeline to drain before touching registers.
  task automatic settle();
    in_valid = 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_SHORT_LEVEL:  short_lvl = data;
      REG_MEDIUM_LEVEL: med_lvl = data;
      REG_LOW_LEVEL:    lowv_lvl = data;
      REG_TURBO_TICKS:  turbo_lim = data;
      REG_MEMORY:       mem_en = data[0];
      REG_LOW_REPEAT:   low_rep = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random events, mostly well-formed runs: press bursts, some long enough to flip
  // the group, tick runs that can outlast the turbo timeout, low-battery runs.
  task automatic run_phase(input int quota);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        len = ($urandom_range(1) != 0) ? $urandom_range(17, 15) : $urandom_range(14, 1);
        repeat (len)
          drive_event(make_event(OP_POWER_UP, pick_cap(PRESS_SHORT), 8'($urandom)), 1'b0, '0);
      end else if (pick < 45) begin
        len = $urandom_range(4, 1);
        repeat (len)
          drive_event(make_event(OP_POWER_UP, pick_cap(PRESS_MEDIUM), 8'($urandom)), 1'b0, '0);
      end else if (pick < 53) begin
        len = 1;
        drive_event(make_event(OP_POWER_UP, pick_cap(PRESS_LONG), 8'($urandom)), 1'b0, '0);
      end else if (pick < 68) begin
        len = $urandom_range((int'(turbo_lim) + 4 < 70) ? int'(turbo_lim) + 4 : 70, 1);
        repeat (len)
          drive_event(make_event(OP_TICK, 8'($urandom), 8'($urandom)), 1'b0, '0);
      end else if (pick < 78) begin
        len = $urandom_range(17, 1);
        repeat (len)
          drive_event(make_event(OP_SAMPLE, 8'($urandom), pick_battery(1'b1)), 1'b0, '0);
      end else if (pick < 88) begin
        len = $urandom_range(3, 1);
        repeat (len)
          drive_event(make_event(OP_SAMPLE, 8'($urandom), pick_battery(1'b0)), 1'b0, '0);
      end else begin
        // Noise: any opcode, the unused one included, with random readings.
        len = $urandom_range(4, 1);
        repeat (len)
          drive_event(make_event(opcode_t'($urandom_range(3)), 8'($urandom), 8'($urandom)),
                      1'b0, '0);
      end
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string field, input logic [15:0] want_v,
                               input logic [15:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
    end
  endtask

  // Sample the result channel at the rising edge; a beat moves when valid is
  // high and stall is low, and it must match the oldest pending prediction.
  always @(posedge clk) begin : result_watch
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (responses_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending, expected none, actual %p",
                 $time, out_item);
      end else begin
        want = responses_due.pop_front();
        compare_field("mode_index", 16'(want.mode_index), 16'(out_item.mode_index));
        compare_field("main_level", 16'(want.main_level), 16'(out_item.main_level));
        compare_field("aux_level", 16'(want.aux_level), 16'(out_item.aux_level));
        compare_field("fast_pwm", 16'(want.fast_pwm), 16'(out_item.fast_pwm));
        compare_field("mode_kind", 16'(want.mode_kind), 16'(out_item.mode_kind));
        compare_field("config_toggled", 16'(want.config_toggled),
                      16'(out_item.config_toggled));
        compare_field("shutdown", 16'(want.shutdown), 16'(out_item.shutdown));
        compare_field("battery_blinks", 16'(want.battery_blinks),
                      16'(out_item.battery_blinks));
        compare_field("store_write", 16'(want.store_write), 16'(out_item.store_write));
        compare_field("store_word", want.store_word, out_item.store_word);
        compare_field("store_slot", 16'(want.store_slot), 16'(out_item.store_slot));
      end
    end
  end

  // Count cycles with no handshake on any channel; a long quiet spell means
  // the block hung.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Back-pressure on the result side: mostly short holds, a few long ones,
  // and occasional long stretches with no stall at all.
  initial begin : stall_pattern
    int r;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      r = $urandom_range(99);
      if (r < 45) begin
        out_stall = 1'b0;
        repeat ($urandom_range(30, 1)) @(negedge clk);
      end else if (r < 85) begin
        out_stall = 1'b1;
        repeat ($urandom_range(3, 1)) @(negedge clk);
      end else if (r < 95) begin
        out_stall = 1'b0;
        repeat ($urandom_range(200, 50)) @(negedge clk);
      end else begin
        out_stall = 1'b1;
        repeat ($urandom_range(60, 20)) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [7:0] reg_vals [6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    // Directed rows under power-on registers. Typed results follow the press
    // path from mode 0 into the hidden modes and back.
    add_row(make_event(OP_SAMPLE, 8'd0, 8'd200), 1'b1,
            result_of(4'd0, 8'd0, 8'd3, 1'b0, KIND_STEADY, 3'd0, 1'b0, 2'd0, 16'h0000, 5'd0));
    add_row(make_event(OP_TICK, 8'd0, 8'd0), 1'b1,
            result_of(4'd0, 8'd0, 8'd3, 1'b0, KIND_STEADY, 3'd0, 1'b0, 2'd0, 16'h0000, 5'd0));
    add_row(make_event(OP_POWER_UP, 8'd255, 8'd0), 1'b1,
            result_of(4'd1, 8'd0, 8'd20, 1'b1, KIND_STEADY, 3'd0, 1'b0, 2'd1, 16'h1001, 5'd2));
    // Unused opcode: state holds, nothing saved.
    add_row(make_event(OP_NONE, 8'd255, 8'd255), 1'b1,
            result_of(4'd1, 8'd0, 8'd20, 1'b1, KIND_STEADY, 3'd0, 1'b0, 2'd0, 16'h0000, 5'd2));
    add_row(make_event(OP_POWER_UP, 8'd200, 8'd0), 1'b1,
            result_of(4'd0, 8'd0, 8'd3, 1'b0, KIND_STEADY, 3'd0, 1'b0, 2'd1, 16'h0000, 5'd4));
    // Medium press below mode 0 wraps into turbo, the last hidden mode.
    add_row(make_event(OP_POWER_UP, 8'd191, 8'd0), 1'b1,
            result_of(4'd9, 8'd255, 8'd255, 1'b0, KIND_STEADY, 3'd0, 1'b0, 2'd1, 16'h0009, 5'd6));
    add_row(make_event(OP_TICK, 8'd0, 8'd0), 1'b1,
            result_of(4'd9, 8'd255, 8'd255, 1'b0, KIND_STEADY, 3'd0, 1'b0, 2'd0, 16'h0000, 5'd6));
    // A reading equal to the short level is still a medium press.
    add_row(make_event(OP_POWER_UP, 8'd250, 8'd0), 1'b1,
            result_of(4'd8, 8'd0, 8'd0, 1'b0, KIND_STROBE, 3'd0, 1'b0, 2'd1, 16'h0008, 5'd8));
    add_row(make_event(OP_TICK, 8'd0, 8'd0), 1'b1,
            result_of(4'd8, 8'd0, 8'd0, 1'b0, KIND_STROBE, 3'd0, 1'b0, 2'd0, 16'h0000, 5'd8));
    add_row(make_event(OP_POWER_UP, 8'd200, 8'd0), 1'b1,
            result_of(4'd7, 8'd0, 8'd0, 1'b0, KIND_BATT, 3'd0, 1'b0, 2'd1, 16'h0007, 5'd10));
    // Battery check: blinks only on samples, all five thresholds at full scale.
    add_row(make_event(OP_SAMPLE, 8'd0, 8'd255), 1'b1,
            result_of(4'd7, 8'd0, 8'd0, 1'b0, KIND_BATT, 3'd5, 1'b0, 2'd0, 16'h0000, 5'd10));
    add_row(make_event(OP_SAMPLE, 8'd0, 8'd118), 1'b1,
            result_of(4'd7, 8'd0, 8'd0, 1'b0, KIND_BATT, 3'd0, 1'b0, 2'd0, 16'h0000, 5'd10));
    add_row(make_event(OP_SAMPLE, 8'd0, 8'd0), 1'b1,
            result_of(4'd7, 8'd0, 8'd0, 1'b0, KIND_BATT, 3'd0, 1'b0, 2'd0, 16'h0000, 5'd10));
    // Medium press from the first hidden mode goes back to mode 0.
    add_row(make_event(OP_POWER_UP, 8'd191, 8'd0), 1'b1,
            result_of(4'd0, 8'd0, 8'd3, 1'b0, KIND_STEADY, 3'd0, 1'b0, 2'd1, 16'h0000, 5'd12));
    add_row(make_event(OP_POWER_UP, 8'd190, 8'd0), 1'b1,
            result_of(4'd0, 8'd0, 8'd3, 1'b0, KIND_STEADY, 3'd0, 1'b0, 2'd1, 16'h0000, 5'd14));
    add_row(make_event(OP_POWER_UP, 8'd0, 8'd0), 1'b1,
            result_of(4'd0, 8'd0, 8'd3, 1'b0, KIND_STEADY, 3'd0, 1'b0, 2'd1, 16'h0000, 5'd16));
    // From here on: repeat zero and memory on. A sample at mode 0 shuts off,
    // and the halt holds through ticks and samples until the next power-up.
    add_row(make_event(OP_SAMPLE, 8'd0, 8'd255), 1'b1,
            result_of(4'd0, 8'd0, 8'd0, 1'b0, KIND_STEADY, 3'd0, 1'b1, 2'd0, 16'h0000, 5'd16));
    add_row(make_event(OP_TICK, 8'd0, 8'd0), 1'b1,
            result_of(4'd0, 8'd0, 8'd0, 1'b0, KIND_STEADY, 3'd0, 1'b1, 2'd0, 16'h0000, 5'd16));
    add_row(make_event(OP_SAMPLE, 8'd0, 8'd0), 1'b1,
            result_of(4'd0, 8'd0, 8'd0, 1'b0, KIND_STEADY, 3'd0, 1'b1, 2'd0, 16'h0000, 5'd16));
    add_row(make_event(OP_POWER_UP, 8'd255, 8'd0), 1'b1,
            result_of(4'd1, 8'd0, 8'd20, 1'b1, KIND_STEADY, 3'd0, 1'b0, 2'd1, 16'h1001, 5'd18));
    add_row(make_event(OP_SAMPLE, 8'd0, 8'd200), 1'b1,
            result_of(4'd0, 8'd0, 8'd3, 1'b0, KIND_STEADY, 3'd0, 1'b0, 2'd1, 16'h1000, 5'd20));
    // Walk up two modes, then a long press that memory must not reset.
    add_row(make_event(OP_POWER_UP, 8'd255, 8'd0), 1'b0, '0);
    add_row(make_event(OP_POWER_UP, 8'd251, 8'd0), 1'b0, '0);
    add_row(make_event(OP_POWER_UP, 8'd10, 8'd0), 1'b0, '0);

    // Hold reset low, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < stim_table.size(); i++) begin
      if (i == HALT_ROW) begin
        settle();
        write_reg(REG_LOW_REPEAT, 8'd0);
        write_reg(REG_MEMORY, 8'd1);
      end
      drive_event(stim_table[i].ev, stim_table[i].typed, stim_table[i].want);
    end

    // Random phases, each under its own register setting. The fixed ones
    // cover the threshold extremes; the last one drives junk upper bits into
    // the narrow registers.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: reg_vals = '{8'd250, 8'd190, 8'd109, 8'd60, 8'd1, 8'd8};
        1: reg_vals = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        2: reg_vals = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd1, 8'd15};
        3: reg_vals = '{8'd200, 8'd100, 8'd150, 8'd3, 8'd0, 8'd1};
        4: reg_vals = '{8'd128, 8'd64, 8'd120, 8'd10, 8'hfe, 8'hf3};
        default: begin
          for (int k = 0; k < 6; k++) reg_vals[k] = 8'($urandom);
        end
      endcase
      settle();
      for (int k = 0; k < 6; k++) write_reg(cfg_reg_t'(k), reg_vals[k]);
      run_phase(ITEMS_PER_PHASE);
    end

    // Drain, then let the clock run on so that any stray beat shows.
    in_valid = 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
